[rtl/assert_macros.svh]
// Assertion macros shared by the predecessor count search RTL.
// No dependencies; include by bare file name ahead of the module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define A51_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a condition is followed by another in the next cycle.
`define A51_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

[rtl/a51pcs_pkg.sv]
// Shared constants and types for the A5/1 predecessor count search.
// No dependencies; used by a51pcs_tables and the top level.
package a51pcs_pkg;

    // Default number of unwinding steps held in the clock-bit tables
    localparam int unsigned TABLE_DEPTH_DEF = 256;

    // Field widths of the request and the result
    localparam int unsigned STATE_W = 64;
    localparam int unsigned DEPTH_W = 8;
    localparam int unsigned COUNT_W = 32;

    // Register layout inside the packed state
    localparam int unsigned R1_W  = 19;
    localparam int unsigned R2_W  = 22;
    localparam int unsigned R3_W  = 23;
    localparam int unsigned R1_LO = 0;
    localparam int unsigned R2_LO = 19;
    localparam int unsigned R3_LO = 41;

    // Clocking bit position of each register
    localparam int unsigned R1_CLK = 8;
    localparam int unsigned R2_CLK = 10;
    localparam int unsigned R3_CLK = 10;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // Clock bits of one search node: bit 0 is R1, bit 1 R2, bit 2 R3.
    // cur is taken at the node's offsets, nxt at offset plus one.
    typedef struct packed {
        logic [2:0] nxt;
        logic [2:0] cur;
    } t_clk_bits;

endpackage

[rtl/a51pcs_tables.sv]
// Clock-bit tables of the three unwound registers: one memory per register,
// one write port and two registered read ports each. Depends on a51pcs_pkg.
module a51pcs_tables #(
    parameter int unsigned  TABLE_DEPTH = a51pcs_pkg::TABLE_DEPTH_DEF,
    localparam int unsigned AW          = $clog2(TABLE_DEPTH)
) (
    input  logic                  i_clk,
    input  logic                  i_wr_en,
    input  logic [AW-1:0]         i_wr_addr,
    input  logic [2:0]            i_wr_bits,
    input  logic                  i_rd_en,
    input  logic [AW-1:0]         i_rd_o1,
    input  logic [AW-1:0]         i_rd_o2,
    input  logic [AW-1:0]         i_rd_o3,
    output a51pcs_pkg::t_clk_bits o_rd_bits
);
    import a51pcs_pkg::*;

    logic      r_mem1 [TABLE_DEPTH];
    logic      r_mem2 [TABLE_DEPTH];
    logic      r_mem3 [TABLE_DEPTH];
    t_clk_bits r_rd;
    logic [AW-1:0] nxt1;
    logic [AW-1:0] nxt2;
    logic [AW-1:0] nxt3;

    // Second read address: one step further back
    assign nxt1 = AW'(i_rd_o1 + 1'b1);
    assign nxt2 = AW'(i_rd_o2 + 1'b1);
    assign nxt3 = AW'(i_rd_o3 + 1'b1);

    // Write one step of all three tables
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem1[i_wr_addr] <= i_wr_bits[0];
            r_mem2[i_wr_addr] <= i_wr_bits[1];
            r_mem3[i_wr_addr] <= i_wr_bits[2];
        end
    end

    // Read current and next clock bits; hold them until the next read
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd.cur[0] <= r_mem1[i_rd_o1];
            r_rd.cur[1] <= r_mem2[i_rd_o2];
            r_rd.cur[2] <= r_mem3[i_rd_o3];
            r_rd.nxt[0] <= r_mem1[nxt1];
            r_rd.nxt[1] <= r_mem2[nxt2];
            r_rd.nxt[2] <= r_mem3[nxt3];
        end
    end

    assign o_rd_bits = r_rd;

endmodule

[rtl/a51_predecessor_count_search_top.sv]
// A request of depth 0 goes straight to posting a count of one.
// Otherwise ST_FILL writes the tables for steps 0 up to the depth, ST_START
// reads the root node, ST_EVAL tries each branch and retires each exhausted
// node, a pop passes ST_POP after a registered read of the stack memory, and
// ST_DONE posts the result. One request is in work at a time.
// Reset (synchronous, active low) clears the sequencer and the result valid.
`include "assert_macros.svh"

module a51_predecessor_count_search_top #(
    parameter int unsigned  TABLE_DEPTH = a51pcs_pkg::TABLE_DEPTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic [a51pcs_pkg::STATE_W-1:0]     i_target_state,
    input  logic [a51pcs_pkg::DEPTH_W-1:0]     i_depth,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic [a51pcs_pkg::COUNT_W-1:0]     o_predecessor_count
);
    import a51pcs_pkg::*;

    localparam int unsigned AW = $clog2(TABLE_DEPTH);
    localparam int unsigned CW = (AW > DEPTH_W) ? AW : DEPTH_W;
    localparam int unsigned SW = 3 * AW + 3;

    // Branch codes: which registers were clocked on the backward step
    localparam logic [2:0] BR_R12  = 3'd0;
    localparam logic [2:0] BR_R13  = 3'd1;
    localparam logic [2:0] BR_R23  = 3'd2;
    localparam logic [2:0] BR_ALL  = 3'd3;
    localparam logic [2:0] BR_DONE = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FILL,
        ST_START,
        ST_EVAL,
        ST_POP,
        ST_DONE
    } t_state;

    t_state               r_state;
    logic [R1_W-1:0]      r_l1;
    logic [R2_W-1:0]      r_l2;
    logic [R3_W-1:0]      r_l3;
    logic [AW-1:0]        r_depth;
    logic [AW-1:0]        r_idx;
    logic [AW-1:0]        r_level;
    logic [AW-1:0]        r_o1;
    logic [AW-1:0]        r_o2;
    logic [AW-1:0]        r_o3;
    logic [2:0]           r_br;
    logic [COUNT_W-1:0]   r_count;
    logic                 r_out_valid;
    logic [COUNT_W-1:0]   r_out_count;

    logic [SW-1:0]        r_stack [TABLE_DEPTH];
    logic [SW-1:0]        r_stack_rd;

    t_clk_bits            tab_bits;
    logic                 tab_wr_en;
    logic                 tab_rd_en;
    logic [AW-1:0]        tab_rd_o1;
    logic [AW-1:0]        tab_rd_o2;
    logic [AW-1:0]        tab_rd_o3;

    logic [CW-1:0]        depth_ext;
    logic [AW-1:0]        depth_sat;
    logic                 in_acc;
    logic                 out_load;
    logic                 a, b, c, a0, b0, c0;
    logic                 ok;
    logic [AW-1:0]        ch_o1;
    logic [AW-1:0]        ch_o2;
    logic [AW-1:0]        ch_o3;
    logic                 exhausted;
    logic                 leaf;
    logic                 push;
    logic                 stk_wr;
    logic                 stk_rd;
    logic [AW-1:0]        pop_o1;
    logic [AW-1:0]        pop_o2;
    logic [AW-1:0]        pop_o3;
    logic [2:0]           pop_br;

    // Clip depth to the table size
    assign depth_ext = CW'(i_depth);
    assign depth_sat = (depth_ext > CW'(TABLE_DEPTH - 1)) ? AW'(TABLE_DEPTH - 1)
                                                          : AW'(i_depth);
    assign in_acc    = i_valid && o_ready;

    // Decode the current branch against the clock bits of the top node
    assign a  = tab_bits.nxt[0];
    assign b  = tab_bits.nxt[1];
    assign c  = tab_bits.nxt[2];
    assign a0 = tab_bits.cur[0];
    assign b0 = tab_bits.cur[1];
    assign c0 = tab_bits.cur[2];

    always_comb begin
        case (r_br)
            BR_R12: begin
                ok    = (a == b) && (a != c0);
                ch_o1 = AW'(r_o1 + 1'b1);
                ch_o2 = AW'(r_o2 + 1'b1);
                ch_o3 = r_o3;
            end
            BR_R13: begin
                ok    = (a == c) && (a != b0);
                ch_o1 = AW'(r_o1 + 1'b1);
                ch_o2 = r_o2;
                ch_o3 = AW'(r_o3 + 1'b1);
            end
            BR_R23: begin
                ok    = (b == c) && (b != a0);
                ch_o1 = r_o1;
                ch_o2 = AW'(r_o2 + 1'b1);
                ch_o3 = AW'(r_o3 + 1'b1);
            end
            BR_ALL: begin
                ok    = (a == b) && (a == c);
                ch_o1 = AW'(r_o1 + 1'b1);
                ch_o2 = AW'(r_o2 + 1'b1);
                ch_o3 = AW'(r_o3 + 1'b1);
            end
            default: begin
                ok    = 1'b0;
                ch_o1 = r_o1;
                ch_o2 = r_o2;
                ch_o3 = r_o3;
            end
        endcase
    end

    assign exhausted = (r_br == BR_DONE);
    assign leaf      = (AW'(r_level + 1'b1) == r_depth);
    assign push      = (r_state == ST_EVAL) && !exhausted && ok && !leaf;
    assign stk_wr    = push;
    assign stk_rd    = (r_state == ST_EVAL) && exhausted && (r_level != '0);

    // Unpack the parent frame read back on a pop
    assign pop_o1 = r_stack_rd[3*AW+2 -: AW];
    assign pop_o2 = r_stack_rd[2*AW+2 -: AW];
    assign pop_o3 = r_stack_rd[AW+2 -: AW];
    assign pop_br = r_stack_rd[2:0];

    // Table access: fill writes, reads whenever a new node comes on top
    assign tab_wr_en = (r_state == ST_FILL);
    assign tab_rd_en = (r_state == ST_START) || push || (r_state == ST_POP);

    always_comb begin
        if (r_state == ST_POP) begin
            tab_rd_o1 = pop_o1;
            tab_rd_o2 = pop_o2;
            tab_rd_o3 = pop_o3;
        end else if (r_state == ST_EVAL) begin
            tab_rd_o1 = ch_o1;
            tab_rd_o2 = ch_o2;
            tab_rd_o3 = ch_o3;
        end else begin
            tab_rd_o1 = '0;
            tab_rd_o2 = '0;
            tab_rd_o3 = '0;
        end
    end

    a51pcs_tables #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_tables (
        .i_clk     (i_clk),
        .i_wr_en   (tab_wr_en),
        .i_wr_addr (r_idx),
        .i_wr_bits ({r_l3[R3_CLK], r_l2[R2_CLK], r_l1[R1_CLK]}),
        .i_rd_en   (tab_rd_en),
        .i_rd_o1   (tab_rd_o1),
        .i_rd_o2   (tab_rd_o2),
        .i_rd_o3   (tab_rd_o3),
        .o_rd_bits (tab_bits)
    );

    // Search stack: parent frames below the top node; push and pop never
    // fall in the same cycle, so a pop always reads a settled entry
    always_ff @(posedge i_clk) begin
        if (stk_wr) begin
            r_stack[r_level] <= {r_o1, r_o2, r_o3, 3'(r_br + 1'b1)};
        end
        if (stk_rd) begin
            r_stack_rd <= r_stack[AW'(r_level - 1'b1)];
        end
    end

    // Post the count once the result register is free
    assign out_load = (r_state == ST_DONE) && (!r_out_valid || i_ready);

    // Result register: load the count, drop it once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
            r_out_count <= r_count;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Sequencer: fill, depth-first search, post the count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (in_acc) begin
                        r_l1    <= i_target_state[R1_LO +: R1_W];
                        r_l2    <= i_target_state[R2_LO +: R2_W];
                        r_l3    <= i_target_state[R3_LO +: R3_W];
                        r_depth <= depth_sat;
                        r_idx   <= '0;
                        r_level <= '0;
                        r_o1    <= '0;
                        r_o2    <= '0;
                        r_o3    <= '0;
                        r_br    <= BR_R12;
                        if (depth_sat == '0) begin
                            r_count <= COUNT_W'(1);
                            r_state <= ST_DONE;
                        end else begin
                            r_count <= '0;
                            r_state <= ST_FILL;
                        end
                    end
                end
                ST_FILL: begin
                    // Step each register one clock backwards
                    r_l1  <= {r_l1[0] ^ r_l1[18] ^ r_l1[17] ^ r_l1[14], r_l1[R1_W-1:1]};
                    r_l2  <= {r_l2[0] ^ r_l2[21], r_l2[R2_W-1:1]};
                    r_l3  <= {r_l3[0] ^ r_l3[22] ^ r_l3[21] ^ r_l3[8], r_l3[R3_W-1:1]};
                    r_idx <= AW'(r_idx + 1'b1);
                    if (r_idx == r_depth) begin
                        r_state <= ST_START;
                    end
                end
                ST_START: begin
                    r_state <= ST_EVAL;
                end
                ST_EVAL: begin
                    if (exhausted) begin
                        if (r_level == '0) begin
                            r_state <= ST_DONE;
                        end else begin
                            r_state <= ST_POP;
                        end
                    end else if (ok && !leaf) begin
                        // Descend into the accepted child
                        r_level <= AW'(r_level + 1'b1);
                        r_o1    <= ch_o1;
                        r_o2    <= ch_o2;
                        r_o3    <= ch_o3;
                        r_br    <= BR_R12;
                    end else begin
                        // Advance to the next branch; count a path that ends here
                        r_br <= 3'(r_br + 1'b1);
                        if (ok) begin
                            r_count <= COUNT_W'(r_count + 1'b1);
                            if (r_count == COUNT_W'(COUNT_MAX - 1'b1)) begin
                                r_state <= ST_DONE;
                            end
                        end
                    end
                end
                ST_POP: begin
                    r_o1    <= pop_o1;
                    r_o2    <= pop_o2;
                    r_o3    <= pop_o3;
                    r_br    <= pop_br;
                    r_level <= AW'(r_level - 1'b1);
                    r_state <= ST_EVAL;
                end
                ST_DONE: begin
                    // Hold until the result register is free
                    if (out_load) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_ready             = (r_state == ST_IDLE);
    assign o_valid             = r_out_valid;
    assign o_predecessor_count = r_out_count;

    `A51_ASSERT(a_eval_below_depth, i_clk, i_rst_n, ((r_state == ST_EVAL) |-> (r_level < r_depth)), "search node at or past target depth")
    `A51_ASSERT(a_eval_branch_range, i_clk, i_rst_n, ((r_state == ST_EVAL) |-> (r_br <= BR_DONE)), "branch code out of range")
    `A51_ASSERT(a_pop_not_root, i_clk, i_rst_n, ((r_state == ST_POP) |-> ($past(r_level) != '0)), "pop issued from the root node")
    `A51_ASSERT_NEXT(a_accept_starts, i_clk, i_rst_n, in_acc, ((r_state == ST_FILL) || (r_state == ST_DONE)), "request did not start work")
    `A51_ASSERT(a_zero_depth_one, i_clk, i_rst_n, (((r_state == ST_DONE) && (r_depth == '0)) |-> (r_count == COUNT_W'(1))), "zero depth must count one path")

endmodule

[dv/a51_predecessor_count_search_top_tb.sv]
// Self-checking testbench for the A5/1 predecessor count search block.
// Depends on a51pcs_pkg and a51_predecessor_count_search_top; predicts each
// count with its own backward search and checks it as the result comes out.
module a51_predecessor_count_search_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import a51pcs_pkg::*;

    localparam int unsigned TDEPTH         = TABLE_DEPTH_DEF;
    localparam int unsigned DEPTH_MAX      = (1 << DEPTH_W) - 1;
    localparam int unsigned RANDOM_ITEMS   = 580;
    localparam int unsigned STEP_CAP       = 6000;
    localparam int unsigned NO_CAP         = 32'hFFFF_FFFF;
    localparam int unsigned HOLDOFF_AT     = 150;
    localparam int unsigned HOLDOFF_CYCLES = 3000;
    localparam int unsigned WATCHDOG_LIMIT = 40000;
    localparam int unsigned DRAIN_CYCLES   = 20;

    // Branch codes of one backward step: which registers were clocked
    localparam int unsigned BR_R1R2 = 0;
    localparam int unsigned BR_R1R3 = 1;
    localparam int unsigned BR_R2R3 = 2;
    localparam int unsigned BR_ALL  = 3;
    localparam int unsigned BR_DONE = 4;

    typedef enum int unsigned {RX_OPEN, RX_CHOPPY, RX_SLOW} rx_mode_t;

    typedef struct {
        logic [STATE_W-1:0] state;
        logic [DEPTH_W-1:0] depth;
    } unwind_req_t;

    typedef struct {
        int unsigned o1;
        int unsigned o2;
        int unsigned o3;
        int unsigned br;
    } search_node_t;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_valid = 1'b0;
    logic                 o_ready;
    logic [STATE_W-1:0]   i_target_state = '0;
    logic [DEPTH_W-1:0]   i_depth = '0;
    logic                 o_valid;
    logic                 i_ready = 1'b0;
    logic [COUNT_W-1:0]   o_predecessor_count;

    unwind_req_t          request_queue[$];
    logic [COUNT_W-1:0]   expected_counts[$];
    int unsigned          total_requests;
    int unsigned          requests_taken = 0;
    int unsigned          results_seen = 0;
    int unsigned          err_count = 0;
    bit                   req_taken = 1'b0;

    // sender burst state
    int unsigned          burst_left = 0;
    int unsigned          gap_left = 0;

    // receiver stall state
    rx_mode_t             rx_mode = RX_OPEN;
    int unsigned          phase_left = 0;
    int unsigned          holdoff_left = 0;
    bit                   holdoff_done = 1'b0;

    a51_predecessor_count_search_top #(
        .TABLE_DEPTH(TDEPTH)
    ) DUT (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_ready            (o_ready),
        .i_target_state     (i_target_state),
        .i_depth            (i_depth),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_predecessor_count(o_predecessor_count)
    );

    initial begin : clock_gen
        forever #2 i_clk = ~i_clk;
    end

    // Count backward majority-clocking paths of the given depth. Stops early
    // once step_cap search steps are spent; steps tells how many were used.
    function automatic logic [COUNT_W-1:0] count_paths(
        input logic [STATE_W-1:0] state,
        input logic [DEPTH_W-1:0] depth_in,
        input int unsigned        step_cap,
        output int unsigned       steps
    );
        logic [TDEPTH-1:0]  t1, t2, t3;
        logic [R1_W-1:0]    l1;
        logic [R2_W-1:0]    l2;
        logic [R3_W-1:0]    l3;
        search_node_t       nodes[TDEPTH];
        logic [COUNT_W-1:0] paths;
        int unsigned        lim, sp, o1, o2, o3;
        logic               a, b, c, a0, b0, c0, ok;

        // unwind each register on its own, keeping its clock bit per step
        l1 = state[R1_LO +: R1_W];
        l2 = state[R2_LO +: R2_W];
        l3 = state[R3_LO +: R3_W];
        for (int i = 0; i < TDEPTH; i++) begin
            t1[i] = l1[R1_CLK];
            t2[i] = l2[R2_CLK];
            t3[i] = l3[R3_CLK];
            l1 = {l1[0] ^ l1[18] ^ l1[17] ^ l1[14], l1[R1_W-1:1]};
            l2 = {l2[0] ^ l2[21], l2[R2_W-1:1]};
            l3 = {l3[0] ^ l3[22] ^ l3[21] ^ l3[8], l3[R3_W-1:1]};
        end

        lim = (depth_in > TDEPTH - 1) ? TDEPTH - 1 : depth_in;
        paths = '0;
        steps = 0;
        nodes[0] = '{0, 0, 0, BR_R1R2};
        sp = 1;

        // depth-first search over the clocked-register choices
        while (sp > 0 && paths != COUNT_MAX && steps < step_cap) begin
            steps++;
            if (sp - 1 == lim) begin
                paths++;
                sp--;
            end else if (nodes[sp-1].br >= BR_DONE) begin
                sp--;
            end else begin
                o1 = nodes[sp-1].o1;
                o2 = nodes[sp-1].o2;
                o3 = nodes[sp-1].o3;
                a  = t1[o1+1];
                b  = t2[o2+1];
                c  = t3[o3+1];
                a0 = t1[o1];
                b0 = t2[o2];
                c0 = t3[o3];
                case (nodes[sp-1].br)
                    BR_R1R2: begin
                        ok = (a == b) && (a != c0);
                        o1++;
                        o2++;
                    end
                    BR_R1R3: begin
                        ok = (a == c) && (a != b0);
                        o1++;
                        o3++;
                    end
                    BR_R2R3: begin
                        ok = (b == c) && (b != a0);
                        o2++;
                        o3++;
                    end
                    BR_ALL: begin
                        ok = (a == b) && (a == c);
                        o1++;
                        o2++;
                        o3++;
                    end
                    default: begin
                        ok = 1'b0;
                    end
                endcase
                nodes[sp-1].br++;
                if (ok) begin
                    nodes[sp] = '{o1, o2, o3, BR_R1R2};
                    sp++;
                end
            end
        end
        return paths;
    endfunction

    // Run the cipher forward n majority clockings; the result then has at
    // least one backward path of depth n to the start state.
    function automatic logic [STATE_W-1:0] clock_forward(
        input logic [STATE_W-1:0] state,
        input int unsigned        n
    );
        logic [R1_W-1:0] r1;
        logic [R2_W-1:0] r2;
        logic [R3_W-1:0] r3;
        logic            maj;

        r1 = state[R1_LO +: R1_W];
        r2 = state[R2_LO +: R2_W];
        r3 = state[R3_LO +: R3_W];
        repeat (n) begin
            maj = (r1[R1_CLK] & r2[R2_CLK]) | (r1[R1_CLK] & r3[R3_CLK])
                | (r2[R2_CLK] & r3[R3_CLK]);
            if (r1[R1_CLK] == maj) r1 = {r1[17:0], r1[18] ^ r1[17] ^ r1[16] ^ r1[13]};
            if (r2[R2_CLK] == maj) r2 = {r2[20:0], r2[21] ^ r2[20]};
            if (r3[R3_CLK] == maj) r3 = {r3[21:0], r3[22] ^ r3[21] ^ r3[20] ^ r3[7]};
        end
        return {r3, r2, r1};
    endfunction

    function automatic logic [STATE_W-1:0] rand_state();
        return {$urandom, $urandom};
    endfunction

    // Mostly shallow depths, now and then a deep one
    function automatic int unsigned pick_depth();
        if ($urandom_range(0, 15) == 0) return $urandom_range(41, DEPTH_MAX);
        return $urandom_range(1, 40);
    endfunction

    // Queue a request; halve the depth while its search is too long to run.
    // A saturated count is never reached, as each search is capped at STEP_CAP steps.
    task automatic queue_request(input logic [STATE_W-1:0] st, input int unsigned dep);
        int unsigned        steps;
        logic [COUNT_W-1:0] unused;

        if (dep > DEPTH_MAX) dep = DEPTH_MAX;
        unused = count_paths(st, dep[DEPTH_W-1:0], STEP_CAP, steps);
        while (steps >= STEP_CAP && dep > 0) begin
            dep = dep / 2;
            unused = count_paths(st, dep[DEPTH_W-1:0], STEP_CAP, steps);
        end
        request_queue.push_back('{st, dep[DEPTH_W-1:0]});
    endtask

    task automatic report_mismatch(
        input string              what,
        input logic [COUNT_W-1:0] got,
        input logic [COUNT_W-1:0] want
    );
        $display("[%0t] mismatch: %s got %0d want %0d", $realtime, what, got, want);
        err_count++;
    endtask

    // Send requests in bursts with random gaps; hold each until taken
    always @(negedge i_clk) begin : driver
        unwind_req_t req;
        logic        valid_next;

        valid_next = i_valid;
        if (i_rst_n && (!i_valid || req_taken)) begin
            valid_next = 1'b0;
            if (gap_left > 0) begin
                gap_left--;
            end else if (request_queue.size() > 0) begin
                req = request_queue.pop_front();
                i_target_state <= req.state;
                i_depth        <= req.depth;
                valid_next = 1'b1;
                if (burst_left > 0) burst_left--;
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 12);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 30);
                end
            end
        end
        req_taken = 1'b0;
        i_valid <= valid_next;
    end

    // Stall the result side on its own pattern, with one long hold-off
    always @(negedge i_clk) begin : receiver
        logic rdy;

        rdy = 1'b0;
        if (i_rst_n) begin
            if (holdoff_left > 0) begin
                holdoff_left--;
            end else if (!holdoff_done && results_seen >= HOLDOFF_AT) begin
                holdoff_left = HOLDOFF_CYCLES;
                holdoff_done = 1'b1;
            end else begin
                if (phase_left == 0) begin
                    rx_mode = rx_mode_t'($urandom_range(0, 2));
                    phase_left = $urandom_range(20, 300);
                end
                phase_left--;
                case (rx_mode)
                    RX_OPEN:   rdy = 1'b1;
                    RX_CHOPPY: rdy = 1'($urandom_range(0, 1));
                    default:   rdy = ($urandom_range(0, 3) == 0);
                endcase
            end
        end
        i_ready <= rdy;
    end

    // Predict on every taken request; check every result against the oldest
    always @(posedge i_clk) begin : monitor
        int unsigned        steps;
        logic [COUNT_W-1:0] want;

        if (i_rst_n) begin
            if (i_valid && o_ready) begin
                expected_counts.push_back(count_paths(i_target_state, i_depth, NO_CAP, steps));
                req_taken = 1'b1;
                requests_taken++;
            end
            if (o_valid && i_ready) begin
                results_seen++;
                if (expected_counts.size() == 0) begin
                    report_mismatch("result with no request pending", o_predecessor_count, '0);
                end else begin
                    want = expected_counts.pop_front();
                    if (o_predecessor_count !== want)
                        report_mismatch("predecessor_count", o_predecessor_count, want);
                end
            end
        end
    end

    // End the run when nothing moves on either side for too long
    initial begin : watchdog
        int unsigned idle_cycles;

        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("TEST FAILED");
        $finish;
    end

    initial begin : main
        int unsigned d;
        int unsigned sel;

        // directed: depth extremes, all-zero and all-one states, lone registers
        queue_request(64'h0, 0);
        queue_request('1, 0);
        queue_request(64'h0, DEPTH_MAX);
        queue_request('1, DEPTH_MAX);
        queue_request(64'h0, 1);
        queue_request('1, 1);
        queue_request(64'h5555_5555_5555_5555, DEPTH_MAX);
        queue_request(64'hAAAA_AAAA_AAAA_AAAA, 128);
        queue_request(64'h0000_0000_0007_FFFF, 8);
        queue_request(64'h0000_01FF_FFF8_0000, 64);
        queue_request(64'hFFFF_FE00_0000_0000, 64);
        queue_request(64'hFFFF_FFFF_FFF8_0000, 16);
        queue_request(64'h0000_01FF_FFFF_FFFF, 16);
        queue_request(clock_forward(rand_state(), 1), 1);
        queue_request(clock_forward(rand_state(), 2), 2);
        queue_request(clock_forward(rand_state(), 100), 100);
        queue_request(clock_forward(rand_state(), DEPTH_MAX), DEPTH_MAX);
        queue_request(rand_state(), 0);
        queue_request(rand_state(), 128);
        queue_request(rand_state(), 127);

        // random: mostly states with a known ancestor, some noise
        repeat (RANDOM_ITEMS) begin
            sel = $urandom_range(0, 19);
            d = pick_depth();
            if (sel < 11)
                queue_request(clock_forward(rand_state(), d), d);
            else if (sel < 16)
                queue_request(rand_state(), ($urandom_range(0, 9) == 0) ? 0 : d);
            else if (sel < 18)
                queue_request(clock_forward(rand_state(), d), d + $urandom_range(1, 3));
            else
                queue_request(rand_state() & rand_state() & rand_state(), d);
        end
        total_requests = request_queue.size();

        // hold reset, then release it away from the sampling edge
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        wait (requests_taken == total_requests && expected_counts.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (err_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
